### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, quiet during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/qrm_pkg.sv
package qrm_pkg;

    localparam int QW    = 16;             // Q2.14 field width
    localparam int QFRAC = 14;
    localparam int PW    = 2 * QW;         // exact product, Q4.28
    localparam int AW    = PW + 2;         // element accumulator
    localparam int RW    = AW + 1 - QFRAC; // rounded, before saturation

    localparam logic signed [QW-1:0] Q_ONE      = 16'sd16384;
    localparam logic signed [AW-1:0] ACC_ONE    = AW'(64'sd1 <<< (2 * QFRAC));
    localparam logic signed [AW:0]   ROUND_BIAS = (AW + 1)'(64'sd1 <<< (QFRAC - 1));

    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [QW-1:0] elem_r0c0;
        logic signed [QW-1:0] elem_r0c1;
        logic signed [QW-1:0] elem_r0c2;
        logic signed [QW-1:0] elem_r1c0;
        logic signed [QW-1:0] elem_r1c1;
        logic signed [QW-1:0] elem_r1c2;
        logic signed [QW-1:0] elem_r2c0;
        logic signed [QW-1:0] elem_r2c1;
        logic signed [QW-1:0] elem_r2c2;
    } mat_t;

    // Round half up from Q6.28 to Q2.14 and clamp to +/-1.0.
    function automatic logic signed [QW-1:0] round_sat(input logic signed [AW-1:0] acc);
        logic signed [AW:0]   biased;
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        hi     = RW'(Q_ONE);
        lo     = -hi;
        biased = (AW + 1)'(acc) + ROUND_BIAS;
        r      = biased[AW:QFRAC];
        if (r > hi) begin
            r = hi;
        end
        if (r < lo) begin
            r = lo;
        end
        return r[QW-1:0];
    endfunction

endpackage

### hw/rtl/quaternion_to_rotation_matrix.sv
// Quaternion to rotation matrix.
//
// Input channel quat (quat_valid / quat_stall) carries one Q2.14 quaternion
// per beat; output channel mat (mat_valid / mat_stall) carries the nine
// Q2.14 elements of the matching 3x3 rotation matrix, rounded half up and
// clamped to +/-1.0. Inputs are not renormalized.
//
// Three register stages: the nine products, the element sums, then
// rounding and saturation into the output register. One beat is accepted
// per cycle while quat_stall is low.
//
// Each stage advances when it is empty or the one after it advances, so a
// stall on mat holds the output beat while earlier stages keep filling
// bubbles; quat_stall rises only once every stage holds a beat. Results
// leave in input order, none dropped or repeated.
//
// Reset empties the pipeline: all stage valid bits clear, mat_valid is low.
`include "assert_macros.svh"

module quaternion_to_rotation_matrix import qrm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  quat_valid,
    output logic  quat_stall,
    input  quat_t quat,
    output logic  mat_valid,
    input  logic  mat_stall,
    output mat_t  mat
);

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic en1;
    logic en2;
    logic en3;

    assign en3 = !s3_valid_reg || !mat_stall;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign quat_stall = !en1;

    // Stage 1: products
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;

    // Stage 2: exact Q6.28 elements
    logic signed [AW-1:0] acc_reg [9];
    logic signed [AW-1:0] acc_next [9];

    mat_t mat_reg;

    always_comb
    begin
        acc_next[0] = ACC_ONE - ((AW'(yy_reg) + AW'(zz_reg)) <<< 1);
        acc_next[1] = (AW'(xy_reg) - AW'(wz_reg)) <<< 1;
        acc_next[2] = (AW'(xz_reg) + AW'(wy_reg)) <<< 1;
        acc_next[3] = (AW'(xy_reg) + AW'(wz_reg)) <<< 1;
        acc_next[4] = ACC_ONE - ((AW'(xx_reg) + AW'(zz_reg)) <<< 1);
        acc_next[5] = (AW'(yz_reg) - AW'(wx_reg)) <<< 1;
        acc_next[6] = (AW'(xz_reg) - AW'(wy_reg)) <<< 1;
        acc_next[7] = (AW'(yz_reg) + AW'(wx_reg)) <<< 1;
        acc_next[8] = ACC_ONE - ((AW'(xx_reg) + AW'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= quat_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && quat_valid)
        begin
            xx_reg <= PW'(quat.quat_x) * PW'(quat.quat_x);
            yy_reg <= PW'(quat.quat_y) * PW'(quat.quat_y);
            zz_reg <= PW'(quat.quat_z) * PW'(quat.quat_z);
            xy_reg <= PW'(quat.quat_x) * PW'(quat.quat_y);
            xz_reg <= PW'(quat.quat_x) * PW'(quat.quat_z);
            yz_reg <= PW'(quat.quat_y) * PW'(quat.quat_z);
            wx_reg <= PW'(quat.quat_w) * PW'(quat.quat_x);
            wy_reg <= PW'(quat.quat_w) * PW'(quat.quat_y);
            wz_reg <= PW'(quat.quat_w) * PW'(quat.quat_z);
        end
        if (en2 && s1_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (en3 && s2_valid_reg)
        begin
            mat_reg.elem_r0c0 <= round_sat(acc_reg[0]);
            mat_reg.elem_r0c1 <= round_sat(acc_reg[1]);
            mat_reg.elem_r0c2 <= round_sat(acc_reg[2]);
            mat_reg.elem_r1c0 <= round_sat(acc_reg[3]);
            mat_reg.elem_r1c1 <= round_sat(acc_reg[4]);
            mat_reg.elem_r1c2 <= round_sat(acc_reg[5]);
            mat_reg.elem_r2c0 <= round_sat(acc_reg[6]);
            mat_reg.elem_r2c1 <= round_sat(acc_reg[7]);
            mat_reg.elem_r2c2 <= round_sat(acc_reg[8]);
        end
    end

    assign mat_valid = s3_valid_reg;
    assign mat       = mat_reg;

    `ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, quat_stall,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && mat_stall,
        "input stalled while the pipeline has room")
    `ASSERT_NEXT(a_stage1_beat_kept, clk, rst_n, s1_valid_reg && !en2, s1_valid_reg,
        "stage 1 beat lost while blocked")
    `ASSERT_IMPL(a_diag_in_range, clk, rst_n, mat_valid,
        mat.elem_r0c0 <= Q_ONE && mat.elem_r0c0 >= -Q_ONE,
        "diagonal element outside +/-1.0")
    `ASSERT_IMPL(a_offdiag_in_range, clk, rst_n, mat_valid,
        mat.elem_r0c1 <= Q_ONE && mat.elem_r0c1 >= -Q_ONE,
        "off-diagonal element outside +/-1.0")

endmodule
